/* design/tea64_pkg.sv */
// Shared types, constants and round functions for the 64-bit word block cipher.
package tea64_pkg;

   localparam int unsigned ROUNDS  = 32;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [WORD_W-1:0] DELTA = 64'h0123_4578_9876_5432;

   // key register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] KEY0_IDX = 8'd0;
   localparam logic [CSR_IDX_W-1:0] KEY1_IDX = 8'd1;
   localparam logic [CSR_IDX_W-1:0] KEY2_IDX = 8'd2;
   localparam logic [CSR_IDX_W-1:0] KEY3_IDX = 8'd3;

   // command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } key_set_type;

   typedef struct packed {
      logic              vld;
      logic              cmd;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } pipe_type;

   function automatic logic [WORD_W-1:0] mix_fn(input logic [WORD_W-1:0] s,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb);
      return ((s << 4) + ka) ^ (s + sum) ^ ((s >> 5) + kb);
   endfunction

   // running sum seen by round idx when encrypting
   function automatic logic [WORD_W-1:0] enc_sum_fn(input int unsigned idx);
      logic [WORD_W-1:0] m;
      m = WORD_W'(idx) + WORD_W'(1);
      return WORD_W'(DELTA * m);
   endfunction

   // running sum seen by round idx when decrypting
   function automatic logic [WORD_W-1:0] dec_sum_fn(input int unsigned idx);
      logic [WORD_W-1:0] m;
      m = WORD_W'(ROUNDS) - WORD_W'(idx);
      return WORD_W'(DELTA * m);
   endfunction

endpackage

/* design/tea64_rnd.sv */
// One cipher round as two pipeline stages, one half-word update in each.
module tea64_rnd (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [tea64_pkg::WORD_W-1:0] enc_sum,
   input  logic [tea64_pkg::WORD_W-1:0] dec_sum,
   input  tea64_pkg::key_set_type   keys,
   input  tea64_pkg::pipe_type      pipe_i,
   output tea64_pkg::pipe_type      pipe_o
);
   import tea64_pkg::*;

   pipe_type          mid_ff, mid_in;
   pipe_type          out_ff, out_in;
   logic [WORD_W-1:0] sum1, sum2;
   logic [WORD_W-1:0] mix1, mix2;

   // stage 1: encrypt updates a from b (k0,k1); decrypt undoes b from a (k2,k3)
   always_comb begin
      mid_in = pipe_i;
      sum1   = (pipe_i.cmd == CMD_DECRYPT) ? dec_sum : enc_sum;
      if (pipe_i.cmd == CMD_DECRYPT) begin
         mix1     = mix_fn(pipe_i.a, sum1, keys.k2, keys.k3);
         mid_in.b = pipe_i.b - mix1;
      end else begin
         mix1     = mix_fn(pipe_i.b, sum1, keys.k0, keys.k1);
         mid_in.a = pipe_i.a + mix1;
      end
   end

   // stage 2: encrypt updates b from new a (k2,k3); decrypt undoes a from new b
   always_comb begin
      out_in = mid_ff;
      sum2   = (mid_ff.cmd == CMD_DECRYPT) ? dec_sum : enc_sum;
      if (mid_ff.cmd == CMD_DECRYPT) begin
         mix2     = mix_fn(mid_ff.b, sum2, keys.k0, keys.k1);
         out_in.a = mid_ff.a - mix2;
      end else begin
         mix2     = mix_fn(mid_ff.a, sum2, keys.k2, keys.k3);
         out_in.b = mid_ff.b + mix2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.vld <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (en) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
      end
   end

   assign pipe_o = out_ff;

endmodule

/* design/tea64_obuf.sv */
// Output register with one skid entry; freezes the pipeline while the skid is full.
module tea64_obuf (
   input  logic                         clock,
   input  logic                         reset,
   input  tea64_pkg::pipe_type          pipe_i,
   output logic                         pipe_en,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tea64_pkg::WORD_W-1:0] rsp_out_first_half,
   output logic [tea64_pkg::WORD_W-1:0] rsp_out_second_half
);
   import tea64_pkg::*;

   logic              rsp_vld_ff, rsp_vld_in;
   logic [WORD_W-1:0] rsp_a_ff, rsp_a_in;
   logic [WORD_W-1:0] rsp_b_ff, rsp_b_in;
   logic              skid_vld_ff, skid_vld_in;
   logic [WORD_W-1:0] skid_a_ff, skid_a_in;
   logic [WORD_W-1:0] skid_b_ff, skid_b_in;
   logic              out_take;

   assign out_take = rsp_vld_ff && !rsp_stall;
   assign pipe_en  = !skid_vld_ff;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_a_in    = rsp_a_ff;
      rsp_b_in    = rsp_b_ff;
      skid_vld_in = skid_vld_ff;
      skid_a_in   = skid_a_ff;
      skid_b_in   = skid_b_ff;
      if (skid_vld_ff) begin
         // pipeline is frozen; drain the skid once the output moves
         if (out_take) begin
            rsp_vld_in  = 1'b1;
            rsp_a_in    = skid_a_ff;
            rsp_b_in    = skid_b_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!rsp_vld_ff || out_take) begin
         rsp_vld_in = pipe_i.vld;
         rsp_a_in   = pipe_i.a;
         rsp_b_in   = pipe_i.b;
      end else if (pipe_i.vld) begin
         skid_vld_in = 1'b1;
         skid_a_in   = pipe_i.a;
         skid_b_in   = pipe_i.b;
      end
   end

   always_ff @(posedge clock) begin
      rsp_a_ff  <= rsp_a_in;
      rsp_b_ff  <= rsp_b_in;
      skid_a_ff <= skid_a_in;
      skid_b_ff <= skid_b_in;
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_out_first_half  = rsp_a_ff;
   assign rsp_out_second_half = rsp_b_ff;

`ifndef SYNTHESIS
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid holds a transaction while the output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_stall) |=> (!skid_vld_ff && rsp_vld_ff))
      else $error("skid not drained after output moved");
`endif

endmodule

/* design/tea64_block_cipher_unit.sv */
// Top level of the pipelined 64-bit word block cipher with key registers.
// Takes one block per cycle while req_stall is low; results leave on rsp in
// acceptance order after one input register, then 32 rounds of two stages
// each (one half-word update of add, xor and add per stage), then an output
// register. A single skid entry behind the output register catches the block
// in flight when rsp_stall rises; while it is occupied the whole pipeline
// holds and req_stall is high. The four 64-bit key words are written through
// the csr port at indexes 0 to 3 (other indexes are ignored), csr_ready is
// always high, and keys must only be changed while no block is in flight.
module tea64_block_cipher_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [tea64_pkg::WORD_W-1:0]    req_first_half,
   input  logic [tea64_pkg::WORD_W-1:0]    req_second_half,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tea64_pkg::WORD_W-1:0]    rsp_out_first_half,
   output logic [tea64_pkg::WORD_W-1:0]    rsp_out_second_half,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tea64_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tea64_pkg::WORD_W-1:0]    csr_wdata
);
   import tea64_pkg::*;

   key_set_type keys_ff, keys_in;
   pipe_type    in_ff, in_in;
   pipe_type    pipe [ROUNDS+1];
   logic        pipe_en;

   assign csr_ready = 1'b1;

   always_comb begin
      keys_in = keys_ff;
      if (csr_valid) begin
         unique case (csr_index)
            KEY0_IDX: keys_in.k0 = csr_wdata;
            KEY1_IDX: keys_in.k1 = csr_wdata;
            KEY2_IDX: keys_in.k2 = csr_wdata;
            KEY3_IDX: keys_in.k3 = csr_wdata;
            default:  keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   // input register
   assign req_stall = !pipe_en;

   always_comb begin
      in_in.vld = req_valid;
      in_in.cmd = req_cmd;
      in_in.a   = req_first_half;
      in_in.b   = req_second_half;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.vld <= 1'b0;
      end else if (pipe_en) begin
         in_ff <= in_in;
      end
   end

   assign pipe[0] = in_ff;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      localparam logic [WORD_W-1:0] ENC_SUM = enc_sum_fn(r);
      localparam logic [WORD_W-1:0] DEC_SUM = dec_sum_fn(r);

      tea64_rnd u_rnd (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .enc_sum (ENC_SUM),
         .dec_sum (DEC_SUM),
         .keys    (keys_ff),
         .pipe_i  (pipe[r]),
         .pipe_o  (pipe[r+1])
      );
   end

   tea64_obuf u_obuf (
      .clock               (clock),
      .reset               (reset),
      .pipe_i              (pipe[ROUNDS]),
      .pipe_en             (pipe_en),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_first_half  (rsp_out_first_half),
      .rsp_out_second_half (rsp_out_second_half)
   );

endmodule

/* tb/tea64_block_cipher_unit_tb.sv */
// Self-checking testbench for the pipelined 64-bit word block cipher unit.
module tea64_block_cipher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tea64_pkg::*;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type first;
      word_type second;
   } cipher_block_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   localparam int unsigned LATENCY     = 66;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam word_type    ALL_ONES    = '1;
   localparam word_type    TOP_BIT     = word_type'(1) << (WORD_W - 1);
   localparam logic [CSR_IDX_W-1:0] LAST_UNUSED_IDX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_cmd         = CMD_ENCRYPT;
   word_type             req_first_half  = '0;
   word_type             req_second_half = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   word_type             rsp_out_first_half;
   word_type             rsp_out_second_half;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   word_type             csr_wdata       = '0;

   // mirror of the key registers and the blocks still owed by the pipeline
   word_type         key_word [4];
   cipher_block_type pending_blocks [$];

   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int unsigned checked_count = 0;
   int unsigned encrypt_count = 0;
   int unsigned decrypt_count = 0;
   int unsigned key_sets      = 0;
   int unsigned burst_left    = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   tea64_block_cipher_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_first_half      (req_first_half),
      .req_second_half     (req_second_half),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_first_half  (rsp_out_first_half),
      .rsp_out_second_half (rsp_out_second_half),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- cipher
   function automatic word_type round_mix(word_type s, word_type sum, word_type ka,
                                          word_type kb);
      return ((s << 4) + ka) ^ (s + sum) ^ ((s >> 5) + kb);
   endfunction

   function automatic cipher_block_type encipher_block(cipher_block_type blk);
      word_type a;
      word_type b;
      word_type sum;
      a   = blk.first;
      b   = blk.second;
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
         sum = sum + DELTA;
         a   = a + round_mix(b, sum, key_word[0], key_word[1]);
         b   = b + round_mix(a, sum, key_word[2], key_word[3]);
      end
      return '{first: a, second: b};
   endfunction

   function automatic cipher_block_type decipher_block(cipher_block_type blk);
      word_type a;
      word_type b;
      word_type sum;
      a   = blk.first;
      b   = blk.second;
      sum = DELTA * word_type'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
         b   = b - round_mix(a, sum, key_word[2], key_word[3]);
         a   = a - round_mix(b, sum, key_word[0], key_word[1]);
         sum = sum - DELTA;
      end
      return '{first: a, second: b};
   endfunction

   // dense random words half the time, with edges and sparse patterns otherwise
   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return word_type'(1) << $urandom_range(0, WORD_W - 1);
         3:       return ~(word_type'(1) << $urandom_range(0, WORD_W - 1));
         4:       return word_type'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ------------------------------------------------------------- stimulus
   // one block transaction; the sender sends in bursts and may idle between them
   task automatic send_block(input logic cmd, input word_type a, input word_type b,
                             output cipher_block_type result);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_first_half  <= a;
      req_second_half <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_DECRYPT) begin
         result = decipher_block('{first: a, second: b});
         decrypt_count++;
      end else begin
         result = encipher_block('{first: a, second: b});
         encrypt_count++;
      end
      pending_blocks.push_back(result);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic stop_traffic();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= KEY3_IDX) key_word[idx[1:0]] = data;
   endtask

   // each key load also throws a write at an unused index, which must not stick
   task automatic load_keys(input word_type k0, input word_type k1, input word_type k2,
                            input word_type k3);
      write_key(KEY0_IDX, k0);
      write_key(KEY1_IDX, k1);
      write_key(KEY2_IDX, k2);
      write_key(KEY3_IDX, k3);
      write_key(CSR_IDX_W'($urandom_range(KEY3_IDX + 1, LAST_UNUSED_IDX)),
                {$urandom, $urandom});
      csr_valid <= 1'b0;
      @(posedge clock);
      key_sets++;
   endtask

   // keys may only move with nothing in flight
   task automatic settle_pipeline();
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_keys();
      cipher_block_type res;
      send_block(CMD_ENCRYPT, '0, '0, res);
      send_block(CMD_DECRYPT, '0, '0, res);
      send_block(CMD_ENCRYPT, ALL_ONES, ALL_ONES, res);
      send_block(CMD_DECRYPT, ALL_ONES, word_type'(1), res);
      stop_traffic();
      settle_pipeline();
   endtask

   task automatic test_extreme_keys();
      cipher_block_type res;
      load_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_block(CMD_ENCRYPT, '0, ALL_ONES, res);
      send_block(CMD_DECRYPT, ALL_ONES, '0, res);
      send_block(CMD_ENCRYPT, TOP_BIT, word_type'(1), res);
      send_block(CMD_DECRYPT, word_type'(1), TOP_BIT, res);
      send_block(CMD_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, res);
      send_block(CMD_DECRYPT, res.first, res.second, res);
      stop_traffic();
      settle_pipeline();
      load_keys('0, ALL_ONES, TOP_BIT, word_type'(1));
      send_block(CMD_ENCRYPT, ALL_ONES, '0, res);
      send_block(CMD_DECRYPT, '0, ALL_ONES, res);
      send_block(CMD_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, res);
      send_block(CMD_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, res);
      stop_traffic();
      settle_pipeline();
   endtask

   task automatic test_ignored_index();
      cipher_block_type res;
      load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      write_key(CSR_IDX_W'(KEY3_IDX + 1), ALL_ONES);
      write_key(LAST_UNUSED_IDX, ALL_ONES);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_block(CMD_ENCRYPT, '0, '0, res);
      send_block(CMD_DECRYPT, res.first, res.second, res);
      send_block(CMD_ENCRYPT, ALL_ONES, TOP_BIT, res);
      send_block(CMD_DECRYPT, ALL_ONES, TOP_BIT, res);
      stop_traffic();
      settle_pipeline();
   endtask

   task automatic run_random_blocks(input int unsigned count);
      cipher_block_type res;
      word_type         a;
      word_type         b;
      int unsigned      sent;
      sent = 0;
      while (sent < count) begin
         a = random_word();
         b = random_word();
         // round trips feed the predicted ciphertext straight back in
         if ($urandom_range(0, 3) == 0) begin
            send_block(CMD_ENCRYPT, a, b, res);
            send_block(CMD_DECRYPT, res.first, res.second, res);
            sent += 2;
         end else begin
            send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, a, b, res);
            sent++;
         end
      end
      stop_traffic();
      settle_pipeline();
   endtask

   task automatic test_random_traffic();
      load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      run_random_blocks(150);
      load_keys('0, '0, '0, '0);
      run_random_blocks(150);
      load_keys(ALL_ONES, '0, ALL_ONES, '0);
      run_random_blocks(150);
      load_keys(random_word(), random_word(), random_word(), random_word());
      run_random_blocks(150);
   endtask

   initial begin
      key_word = '{default: '0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_keys();
      test_extreme_keys();
      test_ignored_index();
      test_random_traffic();
      if (pending_blocks.size() != 0) begin
         $display("%0t: %0d transformed blocks never returned", $time,
                  pending_blocks.size());
         error_count++;
      end
      $display("Checked %0d blocks (%0d encrypt, %0d decrypt) over %0d key loads,",
               checked_count, encrypt_count, decrypt_count, key_sets);
      $display("with bursty input, varied output backpressure and %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------- response
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(32, 256);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (cycle_count[3:0] < 4'd6);
      endcase
   end

   always @(posedge clock) begin
      cipher_block_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected result transaction %h %h", $time,
                     rsp_out_first_half, rsp_out_second_half);
            error_count++;
         end else begin
            want = pending_blocks.pop_front();
            checked_count++;
            if (rsp_out_first_half !== want.first) begin
               $display("%0t: out_first_half expected %h actual %h", $time,
                        want.first, rsp_out_first_half);
               error_count++;
            end
            if (rsp_out_second_half !== want.second) begin
               $display("%0t: out_second_half expected %h actual %h", $time,
                        want.second, rsp_out_second_half);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d blocks outstanding", $time,
                  pending_blocks.size());
         $display("Verification failed");
         $finish;
      end
   end

endmodule
